// File: rtl/dmc_predictive_controller_core_defines.svh
// Assertion macros for the DMC controller core.
// Included by modules that carry concurrent checks; empty bodies in synthesis.
`ifndef DMC_PREDICTIVE_CONTROLLER_CORE_DEFINES_SVH
`define DMC_PREDICTIVE_CONTROLLER_CORE_DEFINES_SVH

`ifndef SYNTHESIS
`define DMC_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`define DMC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define DMC_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg)
`define DMC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

// File: rtl/dmc_pkg.sv
// Package for the DMC controller core: sizes, coefficient tables, helpers, types.
// No dependencies.
`timescale 1ns / 1ps

package dmc_pkg;

  localparam int unsigned HORIZON    = 10;
  localparam int unsigned MODEL_LEN  = 10;
  localparam int unsigned FRAC_BITS  = 16;
  localparam int unsigned TABLE_LEN  = 10;
  localparam int unsigned DATA_W     = 32;
  localparam int unsigned ACC_W      = 48;
  localparam int unsigned GAIN_W     = 16;
  localparam int unsigned GAIN_FRAC  = 16;
  localparam int unsigned CFG_ADDR_W = 4;

  localparam logic [1:0] REG_TARGET    = 2'd0;
  localparam logic [1:0] REG_MODEL_SET = 2'd1;
  localparam logic [1:0] REG_CORR_GAIN = 2'd2;

  localparam logic signed [DATA_W-1:0] TARGET_RST    = '0;
  localparam logic                     MODEL_SET_RST = 1'b1;
  localparam logic [GAIN_W-1:0]        CORR_GAIN_RST = 16'd7209;

  // coefficients in millionths
  localparam logic [31:0] CTL_MICRO [2][TABLE_LEN] = '{
    '{32'd209000, 32'd698000, 32'd1167000, 32'd1470000, 32'd1649000,
      32'd1771000, 32'd1824000, 32'd1794000, 32'd1668000, 32'd1432000},
    '{32'd173118, 32'd602877, 32'd1071223, 32'd1535874, 32'd1908167,
      32'd2151732, 32'd2250668, 32'd2205667, 32'd2025825, 32'd1720388}
  };

  localparam logic [31:0] STEP_MICRO [2][TABLE_LEN] = '{
    '{32'd2200, 32'd8700, 32'd19600, 32'd34800, 32'd54200,
      32'd77800, 32'd105400, 32'd136900, 32'd172100, 32'd211000},
    '{32'd548, 32'd2190, 32'd4924, 32'd8748, 32'd13658,
      32'd19647, 32'd26709, 32'd34837, 32'd44020, 32'd54249}
  };

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ERR,
    ST_MUL,
    ST_RND,
    ST_PASS_A,
    ST_INC,
    ST_PASS_B,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic signed [DATA_W-1:0] target;
    logic                     model_set;
    logic [GAIN_W-1:0]        corr_gain;
  } cfg_t;

  // elaboration-time conversion, rounded to nearest
  function automatic longint unsigned from_micro(input longint unsigned micro,
                                                 input int unsigned frac);
    return ((micro << frac) + 64'd500000) / 64'd1000000;
  endfunction

  function automatic longint unsigned ctl_coef(input int unsigned set,
                                               input int unsigned p,
                                               input int unsigned frac);
    if (p >= TABLE_LEN) return 64'd0;
    return from_micro(64'(CTL_MICRO[set][p]), frac);
  endfunction

  function automatic longint unsigned step_coef(input int unsigned set,
                                                input int unsigned p,
                                                input int unsigned model_len,
                                                input int unsigned frac);
    int unsigned last;
    int unsigned idx;
    last = ((model_len < TABLE_LEN) ? model_len : TABLE_LEN) - 1;
    idx  = (p > last) ? last : p;
    return from_micro(64'(STEP_MICRO[set][idx]), frac);
  endfunction

  function automatic logic signed [DATA_W-1:0] sat32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[DATA_W-1:0];
  endfunction

endpackage

// File: rtl/dmc_predictive_controller_core.sv
// Dynamic matrix control step core.
// A measurement beat comes in on the s_axis channel; one beat of drive and
// increment leaves on m_axis for each measurement. Settings (target, model_set,
// correction_gain) sit on an APB-style port at byte addresses 0, 4 and 8;
// the user must change them only while the core is idle; the core does not enforce this.
// The prediction vector lives in a single-port-read, single-port-write memory;
// each step reads pred[0] for the error, sweeps the vector once to correct,
// shift and build the increment (one entry per cycle, 4-stage pipe), then
// sweeps it again to add the step response. A new measurement is accepted
// only once the core is back in idle after loading the previous result into
// the output register, so one step is finished before the next is taken.
// After reset the prediction is 1.0 in entry 0 and zero elsewhere, drive is
// zero, and settings return to target 0, model_set 1, correction_gain 7209.
// A result waits in the output register while m_axis_tready is low; the next
// measurement is still accepted, but its result holds the core until the
// waiting beat is taken. Depends on dmc_pkg and the submodules.
`timescale 1ns / 1ps

module dmc_predictive_controller_core import dmc_pkg::*; #(
  parameter  int unsigned Horizon  = HORIZON,
  parameter  int unsigned ModelLen = MODEL_LEN,
  parameter  int unsigned FracBits = FRAC_BITS,
  localparam int unsigned AddrW    = (Horizon > 1) ? $clog2(Horizon) : 1
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid_i,
  output logic                  s_axis_tready_o,
  input  logic [31:0]           s_axis_tdata_i,   // [31:0] measurement
  output logic                  m_axis_tvalid_o,
  input  logic                  m_axis_tready_i,
  output logic [63:0]           m_axis_tdata_o,   // [31:0] drive, [63:32] increment
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  cfg_t                     cfg;
  logic                     rd_en, wr_en;
  logic [AddrW-1:0]         rd_addr, wr_addr;
  logic signed [DATA_W-1:0] rd_data, wr_data;
  logic signed [DATA_W-1:0] drive, increment;

  dmc_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  dmc_pred_mem #(
    .Depth    (Horizon),
    .FracBits (FracBits)
  ) u_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data)
  );

  dmc_step_engine #(
    .Horizon  (Horizon),
    .ModelLen (ModelLen),
    .FracBits (FracBits)
  ) u_engine (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg),
    .s_valid_i     (s_axis_tvalid_i),
    .s_ready_o     (s_axis_tready_o),
    .s_meas_i      (s_axis_tdata_i),
    .m_valid_o     (m_axis_tvalid_o),
    .m_ready_i     (m_axis_tready_i),
    .m_drive_o     (drive),
    .m_inc_o       (increment),
    .mem_rd_en_o   (rd_en),
    .mem_rd_addr_o (rd_addr),
    .mem_rd_data_i (rd_data),
    .mem_wr_en_o   (wr_en),
    .mem_wr_addr_o (wr_addr),
    .mem_wr_data_o (wr_data)
  );

  assign m_axis_tdata_o = {increment, drive};

endmodule

// File: rtl/dmc_cfg_regs.sv
// APB-style configuration registers of the DMC controller core.
// Depends on dmc_pkg.
`timescale 1ns / 1ps

module dmc_cfg_regs import dmc_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready,
  output cfg_t                  cfg_o
);

  cfg_t       cfg_q;
  logic       wr_en;
  logic [1:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[CFG_ADDR_W-1:2];
  assign cfg_o   = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.target    <= TARGET_RST;
      cfg_q.model_set <= MODEL_SET_RST;
      cfg_q.corr_gain <= CORR_GAIN_RST;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_TARGET:    cfg_q.target    <= pwdata;
        REG_MODEL_SET: cfg_q.model_set <= pwdata[0];
        REG_CORR_GAIN: cfg_q.corr_gain <= pwdata[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_TARGET:    prdata = cfg_q.target;
      REG_MODEL_SET: prdata = {31'd0, cfg_q.model_set};
      REG_CORR_GAIN: prdata = {16'd0, cfg_q.corr_gain};
      default:       prdata = '0;
    endcase
  end

endmodule

// File: rtl/dmc_pred_mem.sv
// Prediction vector store: one write port, one registered read port.
// Entries not yet written read as their reset value. Depends on dmc_pkg.
`timescale 1ns / 1ps

module dmc_pred_mem import dmc_pkg::*; #(
  parameter  int unsigned Depth    = HORIZON,
  parameter  int unsigned FracBits = FRAC_BITS,
  localparam int unsigned AddrW    = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     rd_en_i,
  input  logic [AddrW-1:0]         rd_addr_i,
  output logic signed [DATA_W-1:0] rd_data_o,
  input  logic                     wr_en_i,
  input  logic [AddrW-1:0]         wr_addr_i,
  input  logic signed [DATA_W-1:0] wr_data_i
);

  localparam logic signed [DATA_W-1:0] ResetOne = DATA_W'(1) << FracBits;

  logic signed [DATA_W-1:0] mem_q [Depth];
  logic signed [DATA_W-1:0] rd_data_q;
  logic [Depth-1:0]         vld_q;
  logic                     rd_vld_q;
  logic                     rd_zero_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      rd_vld_q  <= 1'b0;
      rd_zero_q <= 1'b0;
    end else begin
      if (wr_en_i) begin
        vld_q[wr_addr_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_vld_q  <= vld_q[rd_addr_i];
        rd_zero_q <= (rd_addr_i == '0);
      end
    end
  end

  assign rd_data_o = rd_vld_q ? rd_data_q : (rd_zero_q ? ResetOne : '0);

endmodule

// File: rtl/dmc_step_engine.sv
// Step sequencer and datapath: error, correction/shift pass, increment, step pass.
// Depends on dmc_pkg and the assertion macros header.
`timescale 1ns / 1ps
`include "dmc_predictive_controller_core_defines.svh"

module dmc_step_engine import dmc_pkg::*; #(
  parameter  int unsigned Horizon  = HORIZON,
  parameter  int unsigned ModelLen = MODEL_LEN,
  parameter  int unsigned FracBits = FRAC_BITS,
  localparam int unsigned AddrW    = (Horizon > 1) ? $clog2(Horizon) : 1
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  cfg_t                     cfg_i,
  input  logic                     s_valid_i,
  output logic                     s_ready_o,
  input  logic signed [DATA_W-1:0] s_meas_i,
  output logic                     m_valid_o,
  input  logic                     m_ready_i,
  output logic signed [DATA_W-1:0] m_drive_o,
  output logic signed [DATA_W-1:0] m_inc_o,
  output logic                     mem_rd_en_o,
  output logic [AddrW-1:0]         mem_rd_addr_o,
  input  logic signed [DATA_W-1:0] mem_rd_data_i,
  output logic                     mem_wr_en_o,
  output logic [AddrW-1:0]         mem_wr_addr_o,
  output logic signed [DATA_W-1:0] mem_wr_data_o
);

  localparam int unsigned CoefW  = FracBits + 2;
  localparam int unsigned AProdW = DATA_W + 2 + CoefW;
  localparam int unsigned SProdW = DATA_W + 1 + CoefW;
  localparam int unsigned CProdW = DATA_W + 2 + GAIN_W;
  localparam int unsigned CorrW  = DATA_W + 2;

  localparam logic [AddrW-1:0] IdxLast = AddrW'(Horizon - 1);
  localparam logic [AddrW:0]   CntEnd  = (AddrW + 1)'(Horizon);

  localparam logic signed [AProdW-1:0] AHalf = AProdW'(1) << (FracBits - 1);
  localparam logic signed [SProdW-1:0] SHalf = SProdW'(1) << (FracBits - 1);
  localparam logic signed [CProdW-1:0] CHalf = CProdW'(1) << (GAIN_FRAC - 1);

  logic [CoefW-1:0] ctl_tab  [2][Horizon];
  logic [CoefW-1:0] step_tab [2][Horizon];

  for (genvar s = 0; s < 2; s++) begin : g_set
    for (genvar g = 0; g < Horizon; g++) begin : g_ent
      localparam longint unsigned CtlVal  = ctl_coef(s, g, FracBits);
      localparam longint unsigned StepVal = step_coef(s, g, ModelLen, FracBits);
      assign ctl_tab[s][g]  = CoefW'(CtlVal);
      assign step_tab[s][g] = CoefW'(StepVal);
    end
  end

  state_e state_q, state_d;
  logic [AddrW:0]   cnt_q;
  logic [AddrW-1:0] cnt_idx;
  logic             issue;

  logic signed [DATA_W-1:0] meas_q;
  logic signed [DATA_W:0]   err_q;
  logic signed [CProdW-1:0] cprod_q;
  logic signed [CorrW-1:0]  corr_q;

  logic                     s1_v_q;
  logic [AddrW-1:0]         s1_idx_q;
  logic                     a2_v_q, a3_v_q, a4_v_q;
  logic [AddrW-1:0]         a2_idx_q, a3_idx_q, a4_idx_q;
  logic signed [DATA_W-1:0] newv_q;
  logic signed [DATA_W:0]   diff_q;
  logic signed [AProdW-1:0] aprod_q;
  logic signed [AProdW-1:0] around;
  logic signed [ACC_W-1:0]  acc_q;

  logic signed [DATA_W-1:0] inc_q;
  logic signed [DATA_W-1:0] drive_q;

  logic                     b2_v_q;
  logic [AddrW-1:0]         b2_idx_q;
  logic signed [DATA_W-1:0] rd_q;
  logic signed [SProdW-1:0] sprod_q;
  logic signed [SProdW-1:0] sround;
  logic signed [DATA_W-1:0] bwr;

  logic                     out_v_q;
  logic                     out_load;
  logic signed [DATA_W-1:0] out_drive_q, out_inc_q;

  assign cnt_idx  = cnt_q[AddrW-1:0];
  assign s_ready_o = (state_q == ST_IDLE);
  assign out_load  = (state_q == ST_DONE) && (!out_v_q || m_ready_i);

  always_comb begin
    state_d       = state_q;
    mem_rd_en_o   = 1'b0;
    mem_rd_addr_o = '0;
    issue         = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (s_valid_i) begin
          mem_rd_en_o = 1'b1;
          state_d     = ST_ERR;
        end
      end
      ST_ERR: state_d = ST_MUL;
      ST_MUL: state_d = ST_RND;
      ST_RND: state_d = ST_PASS_A;
      ST_PASS_A: begin
        if (cnt_q < CntEnd) begin
          issue         = 1'b1;
          mem_rd_en_o   = 1'b1;
          mem_rd_addr_o = (cnt_idx == IdxLast) ? IdxLast : cnt_idx + 1'b1;
        end
        if (a4_v_q && a4_idx_q == IdxLast) begin
          state_d = ST_INC;
        end
      end
      ST_INC: state_d = ST_PASS_B;
      ST_PASS_B: begin
        if (cnt_q < CntEnd) begin
          issue         = 1'b1;
          mem_rd_en_o   = 1'b1;
          mem_rd_addr_o = cnt_idx;
        end
        if (b2_v_q && b2_idx_q == IdxLast) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
      s1_v_q  <= 1'b0;
      a2_v_q  <= 1'b0;
      a3_v_q  <= 1'b0;
      a4_v_q  <= 1'b0;
      b2_v_q  <= 1'b0;
      out_v_q <= 1'b0;
      drive_q <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_RND || state_q == ST_INC) begin
        cnt_q <= '0;
      end else if (issue) begin
        cnt_q <= cnt_q + 1'b1;
      end
      s1_v_q <= issue;
      a2_v_q <= s1_v_q && (state_q == ST_PASS_A);
      a3_v_q <= a2_v_q;
      a4_v_q <= a3_v_q;
      b2_v_q <= s1_v_q && (state_q == ST_PASS_B);
      if (state_q == ST_PASS_B && cnt_q == '0) begin
        drive_q <= sat32(64'(drive_q) + 64'(inc_q));
      end
      if (out_load) begin
        out_v_q <= 1'b1;
      end else if (m_ready_i) begin
        out_v_q <= 1'b0;
      end
    end
  end

  assign around = (aprod_q + AHalf) >>> FracBits;
  assign sround = (sprod_q + SHalf) >>> FracBits;
  assign bwr    = sat32(64'(rd_q) + 64'(sround));

  always_ff @(posedge clk_i) begin
    if (s_valid_i && s_ready_o) begin
      meas_q <= s_meas_i;
    end
    if (state_q == ST_ERR) begin
      err_q <= (DATA_W + 1)'(meas_q) - (DATA_W + 1)'(mem_rd_data_i);
    end
    if (state_q == ST_MUL) begin
      cprod_q <= $signed({1'b0, cfg_i.corr_gain}) * err_q;
    end
    if (state_q == ST_RND) begin
      corr_q <= CorrW'((cprod_q + CHalf) >>> GAIN_FRAC);
      acc_q  <= '0;
    end else if (a4_v_q) begin
      acc_q <= acc_q + ACC_W'(around);
    end
    s1_idx_q <= cnt_idx;
    // correction and shift pass
    newv_q   <= sat32(64'(mem_rd_data_i) + 64'(corr_q));
    a2_idx_q <= s1_idx_q;
    diff_q   <= (DATA_W + 1)'(cfg_i.target) - (DATA_W + 1)'(newv_q);
    a3_idx_q <= a2_idx_q;
    aprod_q  <= diff_q * $signed({1'b0, ctl_tab[cfg_i.model_set][a3_idx_q]});
    a4_idx_q <= a3_idx_q;
    if (state_q == ST_INC) begin
      inc_q <= sat32(64'(acc_q));
    end
    // step response pass
    rd_q     <= mem_rd_data_i;
    sprod_q  <= inc_q * $signed({1'b0, step_tab[cfg_i.model_set][s1_idx_q]});
    b2_idx_q <= s1_idx_q;
    if (out_load) begin
      out_drive_q <= drive_q;
      out_inc_q   <= inc_q;
    end
  end

  assign mem_wr_en_o   = a2_v_q || b2_v_q;
  assign mem_wr_addr_o = a2_v_q ? a2_idx_q : b2_idx_q;
  assign mem_wr_data_o = a2_v_q ? newv_q : bwr;

  assign m_valid_o = out_v_q;
  assign m_drive_o = out_drive_q;
  assign m_inc_o   = out_inc_q;

  `DMC_ASSERT_IMPL(a_no_rw_same_entry, clk_i, rst_ni, mem_rd_en_o && mem_wr_en_o, mem_rd_addr_o != mem_wr_addr_o, "read and write hit the same entry")
  `DMC_ASSERT_IMPL(a_passes_disjoint, clk_i, rst_ni, a2_v_q, !b2_v_q, "write-back from both passes at once")
  `DMC_ASSERT_NEXT(a_pass_a_exit, clk_i, rst_ni, state_q == ST_PASS_A && a4_v_q && a4_idx_q == IdxLast, state_q == ST_INC, "increment not taken after last term")
  `DMC_ASSERT_IMPL(a_out_from_done, clk_i, rst_ni, $rose(out_v_q), $past(state_q) == ST_DONE, "result beat loaded outside done state")

endmodule

// File: tb/sv/tb_dmc_predictive_controller_core.sv
// Self-checking testbench for dmc_predictive_controller_core: streams measurement
// beats, predicts drive and increment in a scoreboard class, checks every result.
// Depends on dmc_pkg and the core RTL.
`timescale 1ns / 1ps

module tb_dmc_predictive_controller_core;
  import dmc_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 1_000_000;
  localparam int unsigned SETTLE_WAIT  = 2 * HORIZON + 20;
  localparam int unsigned PHASES       = 8;
  localparam int unsigned PHASE_ITEMS  = 92;
  localparam logic [1:0]  REG_UNUSED   = 2'd3;

  typedef struct packed {
    logic signed [DATA_W-1:0] increment;
    logic signed [DATA_W-1:0] drive;
  } ctl_beat_t;

  class dmc_scoreboard;
    logic signed [DATA_W-1:0] pred [HORIZON];
    logic signed [DATA_W-1:0] drive_acc;
    logic signed [DATA_W-1:0] target;
    logic                     model_set;
    logic [GAIN_W-1:0]        corr_gain;
    ctl_beat_t                expected_q [$];
    int                       errors;
    int                       checked;
    int                       accepted;

    function new();
      foreach (pred[p]) pred[p] = '0;
      pred[0]   = DATA_W'(1 << FRAC_BITS);
      drive_acc = '0;
      target    = TARGET_RST;
      model_set = MODEL_SET_RST;
      corr_gain = CORR_GAIN_RST;
      errors    = 0;
      checked   = 0;
      accepted  = 0;
    endfunction

    function automatic logic signed [DATA_W-1:0] clip(longint v);
      if (v > 64'sd2147483647) return 32'sh7fffffff;
      if (v < -64'sd2147483648) return 32'sh80000000;
      return v[DATA_W-1:0];
    endfunction

    function automatic longint round_q(longint v, int unsigned sh);
      return (v + (longint'(1) <<< (sh - 1))) >>> sh;
    endfunction

    function automatic longint micro_to_q(logic [31:0] micro);
      return ((longint'(micro) << FRAC_BITS) + 64'sd500000) / 64'sd1000000;
    endfunction

    function automatic longint ctl_weight(int unsigned p);
      if (p >= TABLE_LEN) return 0;
      return micro_to_q(CTL_MICRO[int'(model_set)][p]);
    endfunction

    function automatic longint step_weight(int unsigned p);
      int unsigned last;
      last = ((MODEL_LEN < TABLE_LEN) ? MODEL_LEN : TABLE_LEN) - 1;
      return micro_to_q(STEP_MICRO[int'(model_set)][(p > last) ? last : p]);
    endfunction

    function void set_reg(logic [1:0] idx, logic [31:0] val);
      case (idx)
        REG_TARGET:    target    = val;
        REG_MODEL_SET: model_set = val[0];
        REG_CORR_GAIN: corr_gain = val[GAIN_W-1:0];
        default: ;
      endcase
    endfunction

    function logic [31:0] reg_value(logic [1:0] idx);
      case (idx)
        REG_TARGET:    return target;
        REG_MODEL_SET: return {31'b0, model_set};
        REG_CORR_GAIN: return {16'b0, corr_gain};
        default:       return '0;
      endcase
    endfunction

    function void note_measurement(logic signed [DATA_W-1:0] meas);
      longint    err;
      longint    acc;
      ctl_beat_t beat;
      logic signed [DATA_W-1:0] inc;
      err = longint'(meas) - longint'(pred[0]);
      pred[0] = clip(longint'(pred[0]) + err);
      for (int unsigned p = 1; p < HORIZON; p++)
        pred[p] = clip(longint'(pred[p]) + round_q(longint'(corr_gain) * err, GAIN_FRAC));
      for (int unsigned p = 0; p + 1 < HORIZON; p++) pred[p] = pred[p+1];
      acc = 0;
      for (int unsigned p = 0; p < HORIZON; p++)
        acc += round_q((longint'(target) - longint'(pred[p])) * ctl_weight(p), FRAC_BITS);
      inc       = clip(acc);
      drive_acc = clip(longint'(drive_acc) + longint'(inc));
      for (int unsigned p = 0; p < HORIZON; p++)
        pred[p] = clip(longint'(pred[p]) + round_q(step_weight(p) * longint'(inc), FRAC_BITS));
      beat.drive     = drive_acc;
      beat.increment = inc;
      expected_q.push_back(beat);
      accepted++;
    endfunction

    function void check_beat(logic [63:0] data);
      ctl_beat_t exp_b;
      ctl_beat_t act_b;
      act_b = data;
      if (expected_q.size() == 0) begin
        $error("result beat with nothing expected: drive %0d increment %0d",
               act_b.drive, act_b.increment);
        errors++;
        return;
      end
      exp_b = expected_q.pop_front();
      checked++;
      if (act_b.drive !== exp_b.drive) begin
        $error("drive: expected %0d, got %0d", exp_b.drive, act_b.drive);
        errors++;
      end
      if (act_b.increment !== exp_b.increment) begin
        $error("increment: expected %0d, got %0d", exp_b.increment, act_b.increment);
        errors++;
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic                  clk_i    = 1'b0;
  logic                  rst_ni   = 1'b0;
  logic                  s_tvalid = 1'b0;
  logic [31:0]           s_tdata  = '0;
  logic                  m_tready = 1'b0;
  logic                  psel     = 1'b0;
  logic                  penable  = 1'b0;
  logic                  pwrite   = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr    = '0;
  logic [31:0]           pwdata   = '0;
  logic                  s_tready;
  logic                  m_tvalid;
  logic [63:0]           m_tdata;
  logic [31:0]           prdata;
  logic                  pready;

  dmc_scoreboard sb;
  bit            idle_on;
  int            settings_used;

  dmc_predictive_controller_core u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  function automatic int gap_len();
    int r;
    if (!idle_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 4);
    return $urandom_range(20, 120);
  endfunction

  function automatic logic [31:0] pick_measurement(logic [31:0] tgt);
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 32'($urandom_range(0, 1 << 20)) - 32'(1 << 19);
    if (r < 80) return tgt + 32'($urandom_range(0, 1 << 18)) - 32'(1 << 17);
    if (r < 95) return $urandom;
    case ($urandom_range(0, 3))
      0:       return 32'h7fffffff;
      1:       return 32'h80000000;
      2:       return 32'h0;
      default: return 32'hffffffff;
    endcase
  endfunction

  task automatic apb_write(logic [1:0] idx, logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= CFG_ADDR_W'({idx, 2'b00});
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    sb.set_reg(idx, val);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic apb_check(logic [1:0] idx);
    logic [31:0] got;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= CFG_ADDR_W'({idx, 2'b00});
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    got = prdata;
    if (got !== sb.reg_value(idx)) begin
      $error("prdata[%0d]: expected %0h, got %0h", idx, sb.reg_value(idx), got);
      sb.errors++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic check_regs();
    apb_check(REG_TARGET);
    apb_check(REG_MODEL_SET);
    apb_check(REG_CORR_GAIN);
  endtask

  task automatic send_measurement(logic [31:0] val);
    int gap;
    gap = gap_len();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= val;
    do @(posedge clk_i); while (!s_tready);
    sb.note_measurement(val);
  endtask

  task automatic end_burst();
    s_tvalid <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SETTLE_WAIT) @(posedge clk_i);
  endtask

  task automatic configure(logic [31:0] tgt, logic set, logic [15:0] gain);
    apb_write(REG_TARGET, tgt);
    apb_write(REG_MODEL_SET, {31'b0, set});
    apb_write(REG_CORR_GAIN, {16'b0, gain});
    check_regs();
    settings_used++;
  endtask

  initial begin : result_sink
    int stall;
    stall = 0;
    forever begin
      if (stall > 0) begin
        m_tready <= 1'b0;
        stall--;
      end else begin
        m_tready <= 1'b1;
        stall = gap_len();
      end
      @(posedge clk_i);
      if (rst_ni && m_tvalid && m_tready) sb.check_beat(m_tdata);
    end
  end

  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("tb_dmc_predictive_controller_core: errors");
    $finish;
  end

  initial begin : stimulus
    logic [31:0] tgt;
    logic [15:0] gain;
    logic        set;
    logic [31:0] corner_meas [9];
    sb            = new();
    idle_on       = 1'b0;
    settings_used = 1;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    check_regs();

    // reset settings: extremes and small values of the measurement
    corner_meas = '{32'h0, 32'h10000, 32'h7fffffff, 32'h80000000, 32'h7fffffff,
                    32'hffffffff, 32'h1, 32'h80000000, 32'h0};
    foreach (corner_meas[i]) send_measurement(corner_meas[i]);
    end_burst();

    // write past the last register must leave all settings untouched
    apb_write(REG_UNUSED, $urandom);
    check_regs();

    configure(32'h7fffffff, 1'b0, 16'hffff);
    idle_on = 1'b1;
    repeat (4) send_measurement(32'h80000000);
    send_measurement(32'h7fffffff);
    send_measurement(32'h0);
    end_burst();

    configure(32'h80000000, 1'b1, 16'h0);
    repeat (4) send_measurement(32'h7fffffff);
    send_measurement(32'h80000000);
    send_measurement(32'hffffffff);
    end_burst();

    for (int ph = 0; ph < PHASES; ph++) begin
      case ($urandom_range(0, 5))
        0:       tgt = 32'h7fffffff;
        1:       tgt = 32'h80000000;
        2:       tgt = 32'h0;
        3:       tgt = $urandom;
        default: tgt = 32'($urandom_range(0, 1 << 21)) - 32'(1 << 20);
      endcase
      case ($urandom_range(0, 4))
        0:       gain = 16'h0;
        1:       gain = 16'hffff;
        2:       gain = CORR_GAIN_RST;
        default: gain = 16'($urandom);
      endcase
      set     = ph[0] ^ 1'($urandom_range(0, 1));
      idle_on = ($urandom_range(0, 3) != 0);
      configure(tgt, set, gain);
      for (int n = 0; n < PHASE_ITEMS; n++) send_measurement(pick_measurement(tgt));
      end_burst();
    end

    $display("run covered %0d measurement beats and %0d checked results", sb.accepted,
             sb.checked);
    $display("over %0d register settings with both tunings, target and gain extremes",
             settings_used);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("tb_dmc_predictive_controller_core: clean");
    end else begin
      $display("tb_dmc_predictive_controller_core: errors");
    end
    $finish;
  end

endmodule

// File: sim.f
+incdir+rtl
rtl/dmc_pkg.sv
rtl/dmc_cfg_regs.sv
rtl/dmc_pred_mem.sv
rtl/dmc_step_engine.sv
rtl/dmc_predictive_controller_core.sv
tb/sv/tb_dmc_predictive_controller_core.sv
